FILE: rtl/core/streaming_substring_replace_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef STREAMING_SUBSTRING_REPLACE_UNIT_ASSERT_SVH
`define STREAMING_SUBSTRING_REPLACE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssr check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssr check failed");

`endif

FILE: rtl/core/ssr_pkg.sv
`default_nettype none
package ssr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int WIN_BYTES       = 8;   // fixed by the 64-bit pattern word
  localparam int WIN_IDX_W       = $clog2(WIN_BYTES);
  localparam int CFG_DW          = 64;
  localparam int LEN_W           = 4;

  localparam int PLEN_CAP_I = (MAX_PATTERN < WIN_BYTES) ? MAX_PATTERN : WIN_BYTES;
  localparam int RLEN_CAP_I = (MAX_REPLACEMENT < WIN_BYTES) ? MAX_REPLACEMENT : WIN_BYTES;

  typedef logic [LEN_W-1:0] len_t;

  localparam len_t PLEN_CAP = len_t'(PLEN_CAP_I);
  localparam len_t RLEN_CAP = len_t'(RLEN_CAP_I);

  typedef enum logic [1:0] {
    REG_PAT_BYTES  = 2'd0,
    REG_PAT_LEN    = 2'd1,
    REG_REPL_BYTES = 2'd2,
    REG_REPL_LEN   = 2'd3
  } cfg_idx_t;

  // Clamped configuration as seen by the match logic.
  typedef struct packed {
    logic [CFG_DW-1:0] pat;
    len_t              plen;
    logic [CFG_DW-1:0] repl;
    len_t              rlen;
    logic              clr;    // pattern rewritten: drop the window
  } ssr_cfg_t;

  // Results of one input word, drained one per cycle while the output is not stalled.
  typedef struct packed {
    logic [WIN_BYTES*8-1:0] bytes;
    len_t                   cnt;
    logic                   bvld;  // zero only for a bare end marker
    logic                   eos;
  } ssr_bundle_t;

endpackage
`default_nettype wire

FILE: rtl/core/ssr_cfg_regs.sv
`default_nettype none
module ssr_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [ssr_pkg::CFG_DW-1:0] cfg_data,
  output ssr_pkg::ssr_cfg_t               cfg
);

  logic [ssr_pkg::CFG_DW-1:0] pat_r;
  logic [ssr_pkg::CFG_DW-1:0] repl_r;
  ssr_pkg::len_t              plen_r;
  ssr_pkg::len_t              rlen_r;
  logic                       pat_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r  <= '0;
      repl_r <= '0;
      plen_r <= '0;
      rlen_r <= '0;
    end else begin
      if (cfg_we) begin
        case (ssr_pkg::cfg_idx_t'(cfg_index))
          ssr_pkg::REG_PAT_BYTES:  pat_r  <= cfg_data;
          ssr_pkg::REG_PAT_LEN:    plen_r <= cfg_data[ssr_pkg::LEN_W-1:0];
          ssr_pkg::REG_REPL_BYTES: repl_r <= cfg_data;
          ssr_pkg::REG_REPL_LEN:   rlen_r <= cfg_data[ssr_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pattern write empties the window at the same edge as the write.
  assign pat_wr = cfg_we &&
                  ((ssr_pkg::cfg_idx_t'(cfg_index) == ssr_pkg::REG_PAT_BYTES) ||
                   (ssr_pkg::cfg_idx_t'(cfg_index) == ssr_pkg::REG_PAT_LEN));

  // Lengths above the supported size act as the maximum.
  always_comb begin
    cfg.pat  = pat_r;
    cfg.repl = repl_r;
    cfg.plen = (plen_r > ssr_pkg::PLEN_CAP) ? ssr_pkg::PLEN_CAP : plen_r;
    cfg.rlen = (rlen_r > ssr_pkg::RLEN_CAP) ? ssr_pkg::RLEN_CAP : rlen_r;
    cfg.clr  = pat_wr;
  end

endmodule
`default_nettype wire

FILE: rtl/core/ssr_match.sv
`default_nettype none
module ssr_match (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire ssr_pkg::ssr_cfg_t cfg,
  output ssr_pkg::ssr_bundle_t bnd
);

  localparam int NB = ssr_pkg::WIN_BYTES;
  localparam int IW = ssr_pkg::WIN_IDX_W;

  logic [7:0]    win_r [NB];
  logic [7:0]    win_nxt [NB];
  ssr_pkg::len_t fill_r;
  ssr_pkg::len_t fill_nxt;

  logic [7:0]          w  [NB];
  logic [7:0]          ws [NB];
  logic [NB*8-1:0]     w_flat;
  ssr_pkg::len_t       f0;
  ssr_pkg::len_t       f1;
  logic                full;
  logic                hit;
  logic                pass;

  assign pass = (cfg.plen == '0);
  assign f0   = (fill_r >= cfg.plen) ? '0 : fill_r;
  assign f1   = f0 + ssr_pkg::len_t'(1);
  assign full = (f1 == cfg.plen);

  // Window with the new byte written at the fill point, and its shifted form.
  always_comb begin
    for (int i = 0; i < NB; i++) w[i] = win_r[i];
    w[f0[IW-1:0]] = data_byte;
    for (int i = 0; i < NB - 1; i++) ws[i] = w[i+1];
    ws[NB-1] = 8'h00;
    for (int i = 0; i < NB; i++) w_flat[i*8 +: 8] = w[i];
  end

  always_comb begin
    hit = full;
    for (int i = 0; i < NB; i++) begin
      if ((ssr_pkg::len_t'(i) < cfg.plen) && (w[i] != cfg.pat[i*8 +: 8])) hit = 1'b0;
    end
  end

  // Results: the input byte when the pattern is empty, else the replacement or the window in order, with a count.
  always_comb begin
    bnd.bytes = w_flat;
    bnd.bvld  = 1'b1;
    bnd.eos   = last_byte;
    bnd.cnt   = '0;
    if (pass) begin
      bnd.bytes = {{(NB*8-8){1'b0}}, data_byte};
      bnd.cnt   = ssr_pkg::len_t'(1);
    end else if (hit) begin
      bnd.bytes = cfg.repl;
      bnd.cnt   = cfg.rlen;
      if (last_byte && (cfg.rlen == '0)) begin
        bnd.cnt  = ssr_pkg::len_t'(1);
        bnd.bvld = 1'b0;
      end
    end else if (full) begin
      bnd.cnt = last_byte ? cfg.plen : ssr_pkg::len_t'(1);
    end else begin
      bnd.cnt = last_byte ? f1 : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NB; i++) win_nxt[i] = win_r[i];
    fill_nxt = fill_r;
    if (cfg.clr) begin
      fill_nxt = '0;
    end else if (acc) begin
      if (pass || hit || last_byte) begin
        fill_nxt = '0;
      end else if (full) begin
        for (int i = 0; i < NB; i++) win_nxt[i] = ws[i];
        fill_nxt = cfg.plen - ssr_pkg::len_t'(1);
      end else begin
        for (int i = 0; i < NB; i++) win_nxt[i] = w[i];
        fill_nxt = f1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Bytes beyond the fill point are never read.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NB; i++) win_r[i] <= win_nxt[i];
  end

endmodule
`default_nettype wire

FILE: rtl/core/ssr_emit.sv
`default_nettype none
module ssr_emit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire ssr_pkg::ssr_bundle_t bnd,
  output logic                      busy,
  output logic                      done,     // final word of the burst leaves now
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output logic                      out_out_valid,
  output logic                      out_end_of_string
);

  localparam int IW = ssr_pkg::WIN_IDX_W;

  ssr_pkg::ssr_bundle_t bnd_r;
  logic                 busy_r;
  logic [IW-1:0]        idx_r;
  logic [IW-1:0]        idx_last;
  logic                 at_last;

  assign idx_last = IW'(bnd_r.cnt - ssr_pkg::len_t'(1));
  assign at_last  = (idx_r == idx_last);
  assign busy     = busy_r;
  assign done     = busy_r && !out_stall && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (done) begin
        busy_r <= 1'b0;
      end else if (busy_r && !out_stall) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) bnd_r <= bnd;
  end

  assign out_byte          = bnd_r.bvld ? bnd_r.bytes[{idx_r, 3'b000} +: 8] : 8'h00;
  assign out_out_valid     = bnd_r.bvld;
  assign out_end_of_string = bnd_r.eos && at_last;

endmodule
`default_nettype wire

FILE: rtl/core/streaming_substring_replace_unit.sv
// First result word is valid in the cycle after the input word is taken.
// One input word per cycle while each yields at most one result and the output is
//   not stalled; a word yielding more results blocks the input until its last one leaves.
// Output burst register drains while the next input word is matched.
// Reset (rst_n low, synchronous): config registers zero, window empty, no output.
`default_nettype none
module streaming_substring_replace_unit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration write port
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [ssr_pkg::CFG_DW-1:0] cfg_data,
  // input byte stream
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_data_byte,
  input  wire logic                       in_last_byte,
  // result stream
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_byte,
  output logic                            out_out_valid,
  output logic                            out_end_of_string
);

  ssr_pkg::ssr_cfg_t    cfg;
  ssr_pkg::ssr_bundle_t bnd;
  logic                 acc;
  logic                 load;
  logic                 busy;
  logic                 done;

  // Input is blocked only while a burst still has words beyond the one
  // leaving this cycle.
  assign in_stall  = busy && !done;
  assign acc       = in_valid && !in_stall;
  // A word that only fills the window produces no burst.
  assign load      = acc && (bnd.cnt != '0);
  assign out_valid = busy;

  ssr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Window update and compare against the pattern, one word per cycle while the input is not stalled.
  ssr_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cfg       (cfg),
    .bnd       (bnd)
  );

  // Burst register: input, replacement, evicted byte or flush; one word a cycle unless stalled.
  ssr_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .bnd               (bnd),
    .busy              (busy),
    .done              (done),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_out_valid     (out_out_valid),
    .out_end_of_string (out_end_of_string)
  );

endmodule
`default_nettype wire

FILE: rtl/core/ssr_checker.sv
`default_nettype none
`include "streaming_substring_replace_unit_assert.svh"
module ssr_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       cfg_we,
  input wire logic [1:0]                 cfg_index,
  input wire logic [ssr_pkg::CFG_DW-1:0] cfg_data,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [7:0]                 in_data_byte,
  input wire logic                       in_last_byte,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [7:0]                 out_byte,
  input wire logic                       out_out_valid,
  input wire logic                       out_end_of_string
);

  // stalled result word holds
  `SSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_end_of_string))
  // a blocked output blocks the input
  `SSR_ASSERT_NOW(a_back_press, out_valid && out_stall, in_stall)
  // no input stall with an empty output
  `SSR_ASSERT_NOW(a_no_idle_stall, !out_valid, !in_stall)
  // a bare marker only closes a string and carries zero
  `SSR_ASSERT_NOW(a_bare_end, out_valid && !out_out_valid, out_end_of_string && (out_byte == 8'h00))

endmodule

bind streaming_substring_replace_unit ssr_checker u_ssr_chk (.*);
`default_nettype wire

FILE: tb/tb_top.sv
`default_nettype none
module tb_top;

  // Run guard; the slowest legal run is far below this.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Cycles to let a word that makes no output finish inside the block.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_WORDS = 140;

  // One output word of the string stream.
  typedef struct packed {
    logic [7:0] chr;
    logic       vld;
    logic       eos;
  } str_word_t;

  // Scoreboard: tracks the find/replace window and queues expected output words.
  class replace_checker;
    logic [63:0] pat_word;
    logic [3:0]  pat_len;
    logic [63:0] repl_word;
    logic [3:0]  repl_len;
    logic [7:0]  window [ssr_pkg::WIN_BYTES];
    int unsigned fill;
    str_word_t   expected_out [$];
    int unsigned mismatches;
    int unsigned words_seen;

    function new();
      pat_word   = '0;
      pat_len    = '0;
      repl_word  = '0;
      repl_len   = '0;
      mismatches = 0;
      words_seen = 0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (window[i]) window[i] = 8'h00;
      fill = 0;
    endfunction

    function str_word_t word(logic [7:0] chr, logic vld, logic eos);
      str_word_t w;
      w.chr = chr;
      w.vld = vld;
      w.eos = eos;
      return w;
    endfunction

    function int unsigned clamp(logic [3:0] v, int unsigned lim);
      int unsigned n;
      n = v;
      if (n > lim) n = lim;
      if (n > ssr_pkg::WIN_BYTES) n = ssr_pkg::WIN_BYTES;
      return n;
    endfunction

    // Pattern rewrites drop whatever the window holds.
    function void write_reg(ssr_pkg::cfg_idx_t idx, logic [63:0] val);
      case (idx)
        ssr_pkg::REG_PAT_BYTES: begin
          pat_word = val;
          clear_window();
        end
        ssr_pkg::REG_PAT_LEN: begin
          pat_len = val[3:0];
          clear_window();
        end
        ssr_pkg::REG_REPL_BYTES: repl_word = val;
        ssr_pkg::REG_REPL_LEN:   repl_len = val[3:0];
        default: ;
      endcase
    endfunction

    function void take_input_byte(logic [7:0] b, logic last);
      str_word_t   burst [$];
      int unsigned plen;
      int unsigned rlen;
      bit          hit;
      int          k;
      plen = clamp(pat_len, ssr_pkg::MAX_PATTERN);
      rlen = clamp(repl_len, ssr_pkg::MAX_REPLACEMENT);
      if (plen == 0) begin
        fill = 0;
        expected_out.push_back(word(b, 1'b1, last));
        return;
      end
      if (fill >= plen) fill = 0;
      window[fill] = b;
      fill++;
      if (fill == plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (window[i] != pat_word[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          for (int i = 0; i < rlen; i++)
            burst.push_back(word(repl_word[8*i +: 8], 1'b1, 1'b0));
          clear_window();
        end else begin
          burst.push_back(word(window[0], 1'b1, 1'b0));
          for (int i = 1; i < ssr_pkg::WIN_BYTES; i++) window[i-1] = window[i];
          window[ssr_pkg::WIN_BYTES-1] = 8'h00;
          fill--;
        end
      end
      if (last) begin
        for (int i = 0; i < fill; i++) burst.push_back(word(window[i], 1'b1, 1'b0));
        clear_window();
        if (burst.size() == 0) burst.push_back(word(8'h00, 1'b0, 1'b0));
        k = burst.size() - 1;
        burst[k].eos = 1'b1;
      end
      foreach (burst[i]) expected_out.push_back(burst[i]);
    endfunction

    function void check_output_byte(logic [7:0] b, logic vld, logic eos);
      str_word_t want;
      str_word_t got;
      got = word(b, vld, eos);
      words_seen++;
      if (expected_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("out word %0d unexpected: byte %02h vld %0b eos %0b",
                   words_seen, b, vld, eos);
        return;
      end
      want = expected_out.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("out word %0d: exp byte %02h vld %0b eos %0b, got byte %02h vld %0b eos %0b",
                   words_seen, want.chr, want.vld, want.eos, got.chr, got.vld, got.eos);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  ssr_pkg::cfg_idx_t cfg_index = ssr_pkg::REG_PAT_BYTES;
  logic [63:0]       cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte = 8'h00;
  logic              in_last_byte = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        out_byte;
  logic              out_out_valid;
  logic              out_end_of_string;

  // Set for the tail of the run: no gaps on the input, no stalls on the output.
  bit          no_idle = 1'b0;
  int unsigned cycles = 0;

  replace_checker board = new();

  streaming_substring_replace_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_out_valid     (out_out_valid),
    .out_end_of_string (out_end_of_string)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** streaming_substring_replace_unit: FAILED **");
      $finish;
    end
  end

  // Output monitor: every word taken by the sink is checked against the oldest
  // expectation. Values are read at the edge, before the block updates them.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_output_byte(out_byte, out_out_valid, out_end_of_string);
  end

  // Sink back-pressure: random stall bursts between free runs.
  initial begin
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // Offer one byte, holding it until the block takes it. Valid stays high on
  // return so back-to-back bytes need no dead cycle.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!no_idle && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_input_byte(b, last);
  endtask

  task automatic send_string(input logic [7:0] s [$]);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  // Stop sending, let every expected word come out, then give the block time
  // to finish any byte that produced no output.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.expected_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ssr_pkg::cfg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Length registers get random upper bits; only the low nibble counts.
  task automatic load_cfg(input logic [63:0] pat, input logic [3:0] plen,
                          input logic [63:0] repl, input logic [3:0] rlen);
    wait_idle();
    write_reg(ssr_pkg::REG_PAT_BYTES, pat);
    write_reg(ssr_pkg::REG_PAT_LEN,
              {$urandom, 28'($urandom_range(0, 32'h0FFF_FFFF)), plen});
    write_reg(ssr_pkg::REG_REPL_BYTES, repl);
    write_reg(ssr_pkg::REG_REPL_LEN,
              {$urandom, 28'($urandom_range(0, 32'h0FFF_FFFF)), rlen});
  endtask

  initial begin
    logic [7:0]  str [$];
    logic [7:0]  alpha [3];
    logic [63:0] pat;
    logic [63:0] repl;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int unsigned plen_eff;
    int unsigned target;
    int unsigned nstr;
    int unsigned rand_words;
    int unsigned cut;

    rand_words = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed part ----
    // Reset config: empty pattern, bytes pass straight through.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b1);

    // Pattern "ab" -> "XYZ".
    load_cfg(64'h6261, 4'd2, 64'h5A5958, 4'd3);
    send_string('{8'h78, 8'h61, 8'h62, 8'h61, 8'h62});   // two hits, end on a hit
    send_string('{8'h61});                               // partial window flushed at end
    send_string('{8'h61, 8'h61, 8'h62});                 // miss shifts, then hit

    // Pattern rewrite mid-string: the held 'a' is dropped. The sender also
    // pauses here until the block has emitted everything owed.
    send_byte(8'h7A, 1'b0);
    send_byte(8'h61, 1'b0);
    wait_idle();
    write_reg(ssr_pkg::REG_PAT_BYTES, 64'h6261);
    send_byte(8'h62, 1'b1);

    // Empty replacement: a hit on the last byte leaves only a bare end marker.
    load_cfg(64'h6261, 4'd2, 64'h0, 4'd0);
    send_string('{8'h61, 8'h62});

    // Lengths above the cap clamp to eight; all-ones pattern, all-zeros replacement.
    load_cfg('1, 4'd15, 64'h0, 4'd15);
    send_string('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});

    // ---- Random part ----
    // Each phase picks a config, then sends strings mostly built from pattern
    // copies and prefixes over a small alphabet so hits and near-misses are common.
    while (rand_words < RANDOM_WORDS) begin
      if (rand_words >= RANDOM_WORDS - 40) no_idle = 1'b1;
      foreach (alpha[i]) alpha[i] = 8'($urandom_range(0, 255));
      pat = {$urandom, $urandom};
      for (int i = 0; i < 8; i++)
        if ($urandom_range(0, 3) != 0) pat[8*i +: 8] = alpha[$urandom_range(0, 2)];
      case ($urandom_range(0, 9))
        0:       plen = 4'd0;
        1:       plen = 4'($urandom_range(8, 15));
        default: plen = 4'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0:       repl = '1;
        1:       repl = '0;
        default: repl = {$urandom, $urandom};
      endcase
      rlen = 4'($urandom_range(0, 15));
      load_cfg(pat, plen, repl, rlen);
      plen_eff = (plen > 8) ? 8 : plen;

      nstr = $urandom_range(3, 6);
      repeat (nstr) begin
        if (rand_words >= RANDOM_WORDS) break;
        str.delete();
        target = $urandom_range(1, 12);
        if ($urandom_range(0, 4) == 0) begin
          // noise string
          repeat (target) str.push_back(8'($urandom_range(0, 255)));
        end else begin
          while (str.size() < target) begin
            case ($urandom_range(0, 4))
              0, 1: for (int i = 0; i < plen_eff; i++) str.push_back(pat[8*i +: 8]);
              2: begin
                cut = (plen_eff > 1) ? $urandom_range(1, plen_eff - 1) : 1;
                for (int i = 0; i < cut; i++) str.push_back(pat[8*i +: 8]);
              end
              3:       str.push_back(alpha[$urandom_range(0, 2)]);
              default: str.push_back(8'($urandom_range(0, 255)));
            endcase
          end
        end
        send_string(str);
        rand_words += str.size();
      end
    end

    wait_idle();
    if (board.mismatches == 0 && board.expected_out.size() == 0)
      $display("** streaming_substring_replace_unit: PASSED **");
    else
      $display("** streaming_substring_replace_unit: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim.f
+incdir+rtl/core
rtl/core/ssr_pkg.sv
rtl/core/ssr_cfg_regs.sv
rtl/core/ssr_match.sv
rtl/core/ssr_emit.sv
rtl/core/streaming_substring_replace_unit.sv
rtl/core/ssr_checker.sv
tb/tb_top.sv
